### rtl/artdmx_pkg.sv
// ----------------------------------------------------------------------------
// ArtDmx parser package
// Constants, the packet ID table and the result item type shared by the
// ArtDmx packet parser.
// ----------------------------------------------------------------------------
package artdmx_pkg;

   // First byte of the DMX payload within the packet.
   localparam int DMX_START  = 18;
   // Shortest packet that carries an ID and an opcode.
   localparam int MIN_PACKET = 12;
   // Opcode of a DMX data packet.
   localparam logic [15:0] OPCODE_DMX = 16'h5000;

   // Depth of the result queue; it must hold the two items one byte can cause.
   localparam int RES_DEPTH = 4;
   localparam int RES_PTR_W = $clog2(RES_DEPTH);
   localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

   // Result item kinds.
   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   typedef struct packed {
      logic        result_kind;
      logic [7:0]  payload_byte;
      logic [8:0]  payload_index;
      logic        accepted;
      logic [15:0] opcode;
      logic [15:0] universe;
      logic [7:0]  sequence_res;
      logic [9:0]  dmx_length;
      logic [31:0] sender_address;
      logic [9:0]  packet_size;
      logic        deliver_frame;
      logic        last_result;
   } result_type;

   // Expected packet ID: the text of the protocol name and a zero byte.
   function automatic logic [7:0] id_byte(input logic [2:0] pos);
      logic [7:0] value;
      case (pos)
         3'd0:    value = 8'h41;
         3'd1:    value = 8'h72;
         3'd2:    value = 8'h74;
         3'd3:    value = 8'h2D;
         3'd4:    value = 8'h4E;
         3'd5:    value = 8'h65;
         3'd6:    value = 8'h74;
         default: value = 8'h00;
      endcase
      return value;
   endfunction

endpackage

### rtl/artdmx_packet_parser_top.sv
// ----------------------------------------------------------------------------
// ArtDmx packet parser
// Parses a received datagram one byte per item, streams DMX payload bytes and
// gives a summary item at the end of each packet.
// ----------------------------------------------------------------------------
// Usage:
// The req channel carries one datagram byte per item, with a mark on the
// final byte and the sender address. Items are accepted when req_valid is
// high and req_stall is low. The rsp channel carries result items under the
// same valid/stall rule: a DMX payload item for every payload byte that lies
// within the clamped length while delivery is enabled, and one summary item
// on the final byte of every datagram. A byte causes at most two items.
// The csr channel writes the delivery enable; csr_ready is always high.
// The results of a byte enter the result queue when it is accepted and
// drive rsp from its head. The byte counter and field capture are
// combinational, so one byte is accepted every cycle while req_stall is low.
// Results pass through a four-entry queue; req_stall rises when fewer than
// two entries are free, so a stalled receiver holds off the sender after two
// or three bytes that cause results, and a final byte that itself gives a
// payload item gives two output items in all.
// Reset clears the packet state, the stored fields and the queue, and sets
// delivery enable to one.
// ----------------------------------------------------------------------------
module artdmx_packet_parser_top #(
   parameter int MAX_DMX    = 512,
   parameter int MAX_PACKET = 530
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   input  logic [31:0] req_sender_ip,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_result_kind,
   output logic [7:0]  rsp_payload_byte,
   output logic [8:0]  rsp_payload_index,
   output logic        rsp_accepted,
   output logic [15:0] rsp_opcode,
   output logic [15:0] rsp_universe,
   output logic [7:0]  rsp_sequence_res,
   output logic [9:0]  rsp_dmx_length,
   output logic [31:0] rsp_sender_address,
   output logic [9:0]  rsp_packet_size,
   output logic        rsp_deliver_frame,
   output logic        rsp_last_result,

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_delivery_enable
);

   // The byte counter must hold MAX_PACKET itself, where it saturates.
   localparam int CNT_W  = $clog2(MAX_PACKET + 1);
   // Working width for comparisons between the counter and 16-bit fields.
   localparam int WIDE_W = CNT_W + 17;

   localparam logic [CNT_W-1:0]  CNT_MAX    = CNT_W'(MAX_PACKET);
   localparam logic [WIDE_W-1:0] W_START    = WIDE_W'(artdmx_pkg::DMX_START);
   localparam logic [WIDE_W-1:0] W_MIN      = WIDE_W'(artdmx_pkg::MIN_PACKET);
   localparam logic [WIDE_W-1:0] W_MAX_DMX  = WIDE_W'(MAX_DMX);

   // Per-packet state.
   logic [CNT_W-1:0] byte_count_ff, byte_count_in;
   logic             id_mismatch_ff, id_mismatch_in;
   logic [15:0]      work_opcode_ff, work_opcode_in;
   logic [7:0]       work_sequence_ff, work_sequence_in;
   logic [15:0]      work_universe_ff, work_universe_in;
   logic [15:0]      adv_length_ff, adv_length_in;

   // Fields of the last accepted packet.
   logic [15:0]      kept_opcode_ff, kept_opcode_in;
   logic [15:0]      kept_universe_ff, kept_universe_in;
   logic [9:0]       kept_length_ff, kept_length_in;
   logic [7:0]       kept_sequence_ff, kept_sequence_in;
   logic [31:0]      kept_sender_ff, kept_sender_in;
   logic [9:0]       kept_size_ff, kept_size_in;

   logic             enable_ff, enable_in;

   // Result queue.
   artdmx_pkg::result_type                   queue_ff [artdmx_pkg::RES_DEPTH];
   logic [artdmx_pkg::RES_PTR_W-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [artdmx_pkg::RES_PTR_W-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [artdmx_pkg::RES_CNT_W-1:0]         fill_ff, fill_in;

   // Parsing datapath.
   logic                req_accept, rsp_accept;
   logic                in_range;
   logic [WIDE_W-1:0]   pos_wide, idx_wide, n_wide, avail_wide, len_wide;
   logic [CNT_W-1:0]    count_upd;
   logic                mismatch_upd;
   logic [15:0]         opcode_upd, universe_upd, adv_upd;
   logic [7:0]          sequence_upd;
   logic                is_dmx, pkt_ok, deliver, emit_payload, emit_summary;
   artdmx_pkg::result_type payload_res, summary_res;
   logic [artdmx_pkg::RES_PTR_W-1:0] summary_ptr;
   logic [artdmx_pkg::RES_CNT_W-1:0] push_count;

   assign req_accept = req_valid && !req_stall;
   assign rsp_accept = rsp_valid && !rsp_stall;
   assign csr_ready  = 1'b1;

   // Keep room for the two results that any byte may cause.
   assign req_stall = fill_ff > artdmx_pkg::RES_CNT_W'(artdmx_pkg::RES_DEPTH - 2);
   assign rsp_valid = fill_ff != '0;

   // Field capture for this byte. Bytes past the buffer size change nothing
   // except that a last mark on them still ends the packet.
   always_comb begin
      in_range     = byte_count_ff < CNT_MAX;
      pos_wide     = WIDE_W'(byte_count_ff);
      idx_wide     = pos_wide - W_START;
      count_upd    = byte_count_ff;
      mismatch_upd = id_mismatch_ff;
      opcode_upd   = work_opcode_ff;
      sequence_upd = work_sequence_ff;
      universe_upd = work_universe_ff;
      adv_upd      = adv_length_ff;
      emit_payload = 1'b0;
      if (in_range) begin
         count_upd = byte_count_ff + CNT_W'(1);
         if (pos_wide < WIDE_W'(8)) begin
            if (req_data_byte != artdmx_pkg::id_byte(byte_count_ff[2:0])) begin
               mismatch_upd = 1'b1;
            end
         end else begin
            case (pos_wide)
               WIDE_W'(8):  opcode_upd[7:0]    = req_data_byte;
               WIDE_W'(9):  opcode_upd[15:8]   = req_data_byte;
               WIDE_W'(12): sequence_upd       = req_data_byte;
               WIDE_W'(14): universe_upd[7:0]  = req_data_byte;
               WIDE_W'(15): universe_upd[15:8] = req_data_byte;
               WIDE_W'(16): adv_upd[15:8]      = req_data_byte;
               WIDE_W'(17): adv_upd[7:0]       = req_data_byte;
               default: begin
                  // Payload byte: inside the advertised length and MAX_DMX.
                  emit_payload = pos_wide >= W_START && !id_mismatch_ff &&
                                 work_opcode_ff == artdmx_pkg::OPCODE_DMX &&
                                 idx_wide < WIDE_W'(adv_length_ff) &&
                                 idx_wide < W_MAX_DMX && enable_ff;
               end
            endcase
         end
      end
   end

   // End-of-packet check and length clamp, on the values after this byte.
   always_comb begin
      n_wide     = WIDE_W'(count_upd);
      is_dmx     = opcode_upd == artdmx_pkg::OPCODE_DMX;
      pkt_ok     = n_wide >= W_MIN && !mismatch_upd && !(is_dmx && n_wide < W_START);
      avail_wide = n_wide - W_START;
      len_wide   = WIDE_W'(adv_upd);
      if (len_wide > avail_wide) begin
         len_wide = avail_wide;
      end
      if (len_wide > W_MAX_DMX) begin
         len_wide = W_MAX_DMX;
      end
      deliver      = pkt_ok && is_dmx && len_wide != '0 && enable_ff;
      emit_summary = req_last_byte;
   end

   // Next values of the per-packet and stored state.
   always_comb begin
      byte_count_in    = byte_count_ff;
      id_mismatch_in   = id_mismatch_ff;
      work_opcode_in   = work_opcode_ff;
      work_sequence_in = work_sequence_ff;
      work_universe_in = work_universe_ff;
      adv_length_in    = adv_length_ff;
      kept_opcode_in   = kept_opcode_ff;
      kept_universe_in = kept_universe_ff;
      kept_length_in   = kept_length_ff;
      kept_sequence_in = kept_sequence_ff;
      kept_sender_in   = kept_sender_ff;
      kept_size_in     = kept_size_ff;
      if (req_accept) begin
         if (req_last_byte) begin
            byte_count_in    = '0;
            id_mismatch_in   = 1'b0;
            work_opcode_in   = '0;
            work_sequence_in = '0;
            work_universe_in = '0;
            adv_length_in    = '0;
            if (pkt_ok) begin
               kept_opcode_in = opcode_upd;
               kept_size_in   = 10'(count_upd);
               kept_sender_in = req_sender_ip;
               // A non-DMX packet leaves the DMX fields of an earlier one.
               if (is_dmx) begin
                  kept_sequence_in = sequence_upd;
                  kept_universe_in = universe_upd;
                  kept_length_in   = 10'(len_wide);
               end
            end
         end else begin
            byte_count_in    = count_upd;
            id_mismatch_in   = mismatch_upd;
            work_opcode_in   = opcode_upd;
            work_sequence_in = sequence_upd;
            work_universe_in = universe_upd;
            adv_length_in    = adv_upd;
         end
      end
      enable_in = enable_ff;
      if (csr_valid && csr_ready) begin
         enable_in = csr_delivery_enable;
      end
   end

   // Result items. The summary reports the stored fields after this update.
   always_comb begin
      payload_res               = '0;
      payload_res.result_kind   = artdmx_pkg::KIND_PAYLOAD;
      payload_res.payload_byte  = req_data_byte;
      payload_res.payload_index = 9'(idx_wide);
      payload_res.last_result   = !req_last_byte;

      summary_res                = '0;
      summary_res.result_kind    = artdmx_pkg::KIND_SUMMARY;
      summary_res.accepted       = pkt_ok;
      summary_res.opcode         = pkt_ok ? opcode_upd : 16'h0000;
      summary_res.universe       = kept_universe_in;
      summary_res.sequence_res   = kept_sequence_in;
      summary_res.dmx_length     = kept_length_in;
      summary_res.sender_address = kept_sender_in;
      summary_res.packet_size    = kept_size_in;
      summary_res.deliver_frame  = deliver;
      summary_res.last_result    = 1'b1;
   end

   // Queue pointer and fill bookkeeping.
   always_comb begin
      push_count = '0;
      if (req_accept) begin
         push_count = artdmx_pkg::RES_CNT_W'(emit_payload) +
                      artdmx_pkg::RES_CNT_W'(emit_summary);
      end
      summary_ptr = wr_ptr_ff + artdmx_pkg::RES_PTR_W'(emit_payload);
      wr_ptr_in   = wr_ptr_ff + artdmx_pkg::RES_PTR_W'(push_count);
      rd_ptr_in   = rd_ptr_ff + artdmx_pkg::RES_PTR_W'(rsp_accept);
      fill_in     = fill_ff + push_count - artdmx_pkg::RES_CNT_W'(rsp_accept);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff    <= '0;
         id_mismatch_ff   <= 1'b0;
         work_opcode_ff   <= '0;
         work_sequence_ff <= '0;
         work_universe_ff <= '0;
         adv_length_ff    <= '0;
         kept_opcode_ff   <= '0;
         kept_universe_ff <= '0;
         kept_length_ff   <= '0;
         kept_sequence_ff <= '0;
         kept_sender_ff   <= '0;
         kept_size_ff     <= '0;
         enable_ff        <= 1'b1;
         wr_ptr_ff        <= '0;
         rd_ptr_ff        <= '0;
         fill_ff          <= '0;
      end else begin
         byte_count_ff    <= byte_count_in;
         id_mismatch_ff   <= id_mismatch_in;
         work_opcode_ff   <= work_opcode_in;
         work_sequence_ff <= work_sequence_in;
         work_universe_ff <= work_universe_in;
         adv_length_ff    <= adv_length_in;
         kept_opcode_ff   <= kept_opcode_in;
         kept_universe_ff <= kept_universe_in;
         kept_length_ff   <= kept_length_in;
         kept_sequence_ff <= kept_sequence_in;
         kept_sender_ff   <= kept_sender_in;
         kept_size_ff     <= kept_size_in;
         enable_ff        <= enable_in;
         wr_ptr_ff        <= wr_ptr_in;
         rd_ptr_ff        <= rd_ptr_in;
         fill_ff          <= fill_in;
      end
   end

   // Queue storage holds payload and summary items only and needs no reset.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         if (emit_payload) begin
            queue_ff[wr_ptr_ff] <= payload_res;
         end
         if (emit_summary) begin
            queue_ff[summary_ptr] <= summary_res;
         end
      end
   end

   // The item at the head of the queue drives the result channel.
   always_comb begin
      rsp_result_kind    = queue_ff[rd_ptr_ff].result_kind;
      rsp_payload_byte   = queue_ff[rd_ptr_ff].payload_byte;
      rsp_payload_index  = queue_ff[rd_ptr_ff].payload_index;
      rsp_accepted       = queue_ff[rd_ptr_ff].accepted;
      rsp_opcode         = queue_ff[rd_ptr_ff].opcode;
      rsp_universe       = queue_ff[rd_ptr_ff].universe;
      rsp_sequence_res   = queue_ff[rd_ptr_ff].sequence_res;
      rsp_dmx_length     = queue_ff[rd_ptr_ff].dmx_length;
      rsp_sender_address = queue_ff[rd_ptr_ff].sender_address;
      rsp_packet_size    = queue_ff[rd_ptr_ff].packet_size;
      rsp_deliver_frame  = queue_ff[rd_ptr_ff].deliver_frame;
      rsp_last_result    = queue_ff[rd_ptr_ff].last_result;
   end

   // The queue never holds more items than it has entries.
   assert property (@(posedge clock) disable iff (reset)
      fill_ff <= artdmx_pkg::RES_CNT_W'(artdmx_pkg::RES_DEPTH))
      else $error("result queue overflow");

   // The byte counter saturates at the buffer size.
   assert property (@(posedge clock) disable iff (reset)
      byte_count_ff <= CNT_MAX)
      else $error("byte counter beyond buffer size");

   // The final byte of a datagram always starts the next packet from zero.
   assert property (@(posedge clock) disable iff (reset)
      req_accept && req_last_byte |=> byte_count_ff == '0 && !id_mismatch_ff)
      else $error("packet state not cleared after final byte");

   // Every accepted byte that ends a datagram adds a summary to the queue.
   assert property (@(posedge clock) disable iff (reset)
      req_accept && req_last_byte && !rsp_accept |=> fill_ff != '0)
      else $error("summary item missing");

endmodule
